### design/tapid_pkg.sv
// two-axis pid controller: shared types, widths and constants
// no dependencies; imported by the interfaces and every module

package tapid_pkg;

    localparam int PosW    = 24;
    localparam int ErrW    = PosW + 1;
    localparam int OpdW    = ErrW + 1;
    localparam int GainW   = 32;
    localparam int StepW   = 16;
    localparam int IntegW  = 48;
    localparam int IntegLoW = 24;
    localparam int ProdW   = OpdW + GainW + 1;
    localparam int AccW    = ProdW + 1;
    localparam int DriveW  = 32;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 32;
    localparam int SeqW    = 4;

    localparam int OPS_PER_AXIS = 5;

    localparam logic [SeqW-1:0] STEP_ISSUE_END = SeqW'(2 * OPS_PER_AXIS);
    localparam logic [SeqW-1:0] STEP_CLAMP_X   = SeqW'(OPS_PER_AXIS + 1);
    localparam logic [SeqW-1:0] STEP_CLAMP_Y   = SeqW'(2 * OPS_PER_AXIS + 1);

    localparam logic [StepW-1:0]         RST_TIME_STEP  = StepW'(655);
    localparam logic [GainW-1:0]         RST_PROP_GAIN  = GainW'(65536);
    localparam logic [GainW-1:0]         RST_INTEG_GAIN = '0;
    localparam logic [GainW-1:0]         RST_DERIV_GAIN = '0;
    localparam logic signed [DriveW-1:0] RST_OUT_MAX    = {1'b0, {(DriveW-1){1'b1}}};
    localparam logic signed [DriveW-1:0] RST_OUT_MIN    = {1'b1, {(DriveW-1){1'b0}}};

    localparam logic signed [IntegW-1:0] INTEG_MAX = {1'b0, {(IntegW-1){1'b1}}};
    localparam logic signed [IntegW-1:0] INTEG_MIN = {1'b1, {(IntegW-1){1'b0}}};

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TIME_STEP  = 3'd0,
        CFG_PROP_GAIN  = 3'd1,
        CFG_INTEG_GAIN = 3'd2,
        CFG_DERIV_GAIN = 3'd3,
        CFG_OUT_MAX    = 3'd4,
        CFG_OUT_MIN    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_DT    = 3'd0,
        OP_KP    = 3'd1,
        OP_KD    = 3'd2,
        OP_KI_LO = 3'd3,
        OP_KI_HI = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

endpackage

### design/tapid_if.sv
// two-axis pid controller: step, drive and configuration channel interfaces
// depends on tapid_pkg

interface tapid_in_if import tapid_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic signed [PosW-1:0] aim_x;
    logic signed [PosW-1:0] aim_y;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;

    modport source (output valid, command, aim_x, aim_y, pos_x, pos_y, input ready);
    modport sink   (input valid, command, aim_x, aim_y, pos_x, pos_y, output ready);
endinterface

interface tapid_out_if import tapid_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DriveW-1:0] drive_x;
    logic signed [DriveW-1:0] drive_y;

    modport source (output valid, drive_x, drive_y, input ready);
    modport sink   (input valid, drive_x, drive_y, output ready);
endinterface

interface tapid_cfg_if import tapid_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/tapid_mul.sv
// two-axis pid controller: shared signed by unsigned multiplier, registered product
// depends on tapid_pkg

module tapid_mul import tapid_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [OpdW-1:0]  i_a,
    input  logic [GainW-1:0]        i_b,
    output logic signed [ProdW-1:0] o_prod
);

    logic signed [GainW:0]    b_s;
    logic signed [ProdW-1:0]  n_prod;
    logic signed [ProdW-1:0]  r_prod;

    assign b_s    = signed'({1'b0, i_b});
    assign n_prod = i_a * b_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### design/two_axis_pid_controller.sv
// two-axis pid controller: top level, sequencer, integrals, accumulator and clamp
// depends on tapid_pkg, tapid_if.sv and tapid_mul
// control step: ten products through one multiplier, then both axes clamped and the drive loaded in the flush state
// clear: zero drive loaded from the flush state once the output register is free; ready only while idle
// a new step or clear item is taken only after the last one is loaded into the output register
// synchronous active-low reset: state and configuration registers to reset values, integrals and last errors to zero

module two_axis_pid_controller import tapid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tapid_in_if.sink    i_step,
    tapid_out_if.source o_drive,
    tapid_cfg_if.sink   i_cfg
);

    t_state r_state;
    logic [SeqW-1:0] r_step;

    logic signed [PosW-1:0]   r_aim   [0:1];
    logic signed [PosW-1:0]   r_pos   [0:1];
    logic signed [IntegW-1:0] r_integ [0:1];
    logic signed [ErrW-1:0]   r_prev  [0:1];
    logic signed [DriveW-1:0] r_res   [0:1];

    logic [StepW-1:0]         r_time_step;
    logic [GainW-1:0]         r_prop_gain;
    logic [GainW-1:0]         r_integ_gain;
    logic [GainW-1:0]         r_deriv_gain;
    logic signed [DriveW-1:0] r_out_max;
    logic signed [DriveW-1:0] r_out_min;

    logic signed [AccW-1:0]   r_acc;
    t_op                      r_acc_op;
    logic                     r_acc_ax;
    logic                     r_acc_vld;

    logic                     r_out_vld;
    logic signed [DriveW-1:0] r_out_x;
    logic signed [DriveW-1:0] r_out_y;

    logic                     in_acc;
    logic                     out_load;
    logic                     iss_en;
    logic                     iss_ax;
    t_op                      iss_op;
    logic signed [ErrW-1:0]   err [0:1];
    logic signed [ErrW-1:0]   cur_err;
    logic signed [OpdW-1:0]   mul_a;
    logic [GainW-1:0]         mul_b;
    logic signed [ProdW-1:0]  prod;
    logic signed [AccW-1:0]   prod_ext;
    logic signed [IntegW:0]   integ_sum;
    logic signed [IntegW-1:0] integ_sat;
    logic signed [AccW-1:0]   max_ext;
    logic signed [AccW-1:0]   min_ext;
    logic signed [DriveW-1:0] clamped;
    logic                     clamp_en;
    logic                     clamp_ax;

    assign i_step.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign in_acc       = i_step.valid && (r_state == ST_IDLE);
    assign out_load     = (r_state == ST_FLUSH) && (!r_out_vld || o_drive.ready);

    assign o_drive.valid   = r_out_vld;
    assign o_drive.drive_x = r_out_x;
    assign o_drive.drive_y = r_out_y;

    // issue side of the sequencer
    assign iss_en = (r_state == ST_RUN) && (r_step < STEP_ISSUE_END);
    assign iss_ax = (r_step >= SeqW'(OPS_PER_AXIS));
    assign iss_op = t_op'(3'(iss_ax ? r_step - SeqW'(OPS_PER_AXIS) : r_step));

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            err[i] = ErrW'(r_aim[i]) - ErrW'(r_pos[i]);
        end
    end

    assign cur_err = err[iss_ax];

    always_comb begin
        case (iss_op)
            OP_DT: begin
                mul_a = OpdW'(cur_err);
                mul_b = GainW'(r_time_step);
            end
            OP_KP: begin
                mul_a = OpdW'(cur_err);
                mul_b = r_prop_gain;
            end
            OP_KD: begin
                mul_a = OpdW'(cur_err) - OpdW'(r_prev[iss_ax]);
                mul_b = r_deriv_gain;
            end
            OP_KI_LO: begin
                mul_a = signed'({2'b00, r_integ[iss_ax][IntegLoW-1:0]});
                mul_b = r_integ_gain;
            end
            OP_KI_HI: begin
                mul_a = OpdW'(signed'(r_integ[iss_ax][IntegW-1:IntegLoW]));
                mul_b = r_integ_gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tapid_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (iss_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // accumulate side
    assign prod_ext  = AccW'(prod);
    assign integ_sum = (IntegW+1)'(r_integ[r_acc_ax]) + signed'(prod[IntegW:0]);

    always_comb begin
        if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
            integ_sat = integ_sum[IntegW] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[IntegW-1:0];
        end
    end

    // clamp, upper bound first
    assign max_ext  = AccW'(r_out_max);
    assign min_ext  = AccW'(r_out_min);
    assign clamp_en = (r_state == ST_RUN) && ((r_step == STEP_CLAMP_X) || (r_step == STEP_CLAMP_Y));
    assign clamp_ax = (r_step == STEP_CLAMP_Y);

    always_comb begin
        if (r_acc > max_ext) begin
            clamped = r_out_max;
        end else if (r_acc < min_ext) begin
            clamped = r_out_min;
        end else begin
            clamped = r_acc[DriveW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_acc_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_time_step  <= RST_TIME_STEP;
            r_prop_gain  <= RST_PROP_GAIN;
            r_integ_gain <= RST_INTEG_GAIN;
            r_deriv_gain <= RST_DERIV_GAIN;
            r_out_max    <= RST_OUT_MAX;
            r_out_min    <= RST_OUT_MIN;
            for (int i = 0; i < 2; i++) begin
                r_integ[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_TIME_STEP:  r_time_step  <= i_cfg.data[StepW-1:0];
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg.data;
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg.data;
                    CFG_DERIV_GAIN: r_deriv_gain <= i_cfg.data;
                    CFG_OUT_MAX:    r_out_max    <= signed'(i_cfg.data);
                    CFG_OUT_MIN:    r_out_min    <= signed'(i_cfg.data);
                    default: ;
                endcase
            end

            r_acc_vld <= iss_en;

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_step <= '0;
                        if (i_step.command) begin
                            for (int i = 0; i < 2; i++) begin
                                r_integ[i] <= '0;
                                r_prev[i]  <= '0;
                            end
                            r_state <= ST_FLUSH;
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_CLAMP_Y) begin
                        r_state <= ST_FLUSH;
                    end
                    if (iss_en && (iss_op == OP_KD)) begin
                        r_prev[iss_ax] <= cur_err;
                    end
                    if (r_acc_vld && (r_acc_op == OP_DT)) begin
                        r_integ[r_acc_ax] <= integ_sat;
                    end
                end
                ST_FLUSH: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_drive.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_aim[0] <= i_step.aim_x;
            r_aim[1] <= i_step.aim_y;
            r_pos[0] <= i_step.pos_x;
            r_pos[1] <= i_step.pos_y;
            if (i_step.command) begin
                r_res[0] <= '0;
                r_res[1] <= '0;
            end
        end
        if (iss_en) begin
            r_acc_op <= iss_op;
            r_acc_ax <= iss_ax;
        end
        if (r_acc_vld) begin
            case (r_acc_op)
                OP_KP:    r_acc <= prod_ext >>> 8;
                OP_KD:    r_acc <= r_acc + (prod_ext >>> 8);
                OP_KI_LO: r_acc <= r_acc + (prod_ext >>> IntegLoW);
                OP_KI_HI: r_acc <= r_acc + prod_ext;
                default: ;
            endcase
        end
        if (clamp_en) begin
            r_res[clamp_ax] <= clamped;
        end
        if (out_load) begin
            r_out_x <= r_res[0];
            r_out_y <= r_res[1];
        end
    end

endmodule

### tb/testbench.sv
// testbench for the two-axis pid controller: directed table, then random phases
// checks every drive item against the in-bench pid predictor or typed row values
// depends on tapid_pkg, tapid_if.sv and two_axis_pid_controller

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tapid_pkg::*;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [CfgIdxW-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] IDX_SPARE_HI = 3'd7;

    localparam logic [PosW-1:0] POS_MAX = {1'b0, {(PosW-1){1'b1}}};
    localparam logic [PosW-1:0] POS_MIN = {1'b1, {(PosW-1){1'b0}}};

    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int NUM_PHASES    = 12;
    localparam int MIX_ITEMS     = 90;
    localparam int SAT_ITEMS     = 320;
    localparam int SAT_TURN      = 220;

    typedef logic signed [95:0] t_wide;

    typedef struct {
        logic signed [DriveW-1:0] x;
        logic signed [DriveW-1:0] y;
    } t_drive_pair;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_STEP,
        ROW_CLEAR
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [CfgIdxW-1:0] idx;
        logic [CfgDatW-1:0] data;
        logic [PosW-1:0]    ax;
        logic [PosW-1:0]    ay;
        logic [PosW-1:0]    px;
        logic [PosW-1:0]    py;
        logic               typed;
        logic [DriveW-1:0]  ex;
        logic [DriveW-1:0]  ey;
    } t_dir_row;

    localparam int NUM_DIRECTED = 33;

    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd100, -24'sd100, 24'sd0, 24'sd0,
          1'b1, 32'sd25600, -32'sd25600},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, POS_MAX, POS_MAX, POS_MIN, 24'sd0,
          1'b1, 32'sh7FFFFFFF, 32'sd2147483392},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, POS_MIN, 24'sd0, POS_MAX, -24'sd1,
          1'b1, 32'sh80000000, 32'sd256},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, -24'sd1, POS_MIN, 24'sd0, 24'sd0,
          1'b1, -32'sd256, 32'sh80000000},
        '{ROW_CLEAR, CFG_TIME_STEP, 32'd0, POS_MAX, POS_MIN, POS_MIN, POS_MAX,
          1'b1, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b1, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_INTEG_GAIN, 32'd65536, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_DERIV_GAIN, 32'd65536, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_TIME_STEP, 32'd65535, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd1000, 24'sd2000, -24'sd500, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd1000, 24'sd2000, -24'sd500, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, POS_MAX, POS_MIN, POS_MIN, POS_MAX,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CLEAR, CFG_TIME_STEP, 32'd0, -24'sd3000, 24'sd77, 24'sd12, -24'sd9000,
          1'b1, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, -24'sd3000, 24'sd77, 24'sd12, -24'sd9000,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_OUT_MAX, -32'sd1000, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_OUT_MIN, 32'sd1000, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd10, -24'sd10, 24'sd4000, -24'sd4000,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, -24'sd40000, 24'sd40000, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_PROP_GAIN, 32'hFFFFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_INTEG_GAIN, 32'hFFFFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_DERIV_GAIN, 32'hFFFFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_OUT_MAX, 32'h7FFFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_OUT_MIN, 32'h80000000, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_TIME_STEP, 32'hFFFF0000, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, POS_MAX, POS_MIN, POS_MIN, POS_MAX,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, POS_MIN, POS_MAX, POS_MAX, POS_MIN,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, CFG_TIME_STEP, 32'h1234FFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, IDX_SPARE_LO, 32'hFFFFFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_CFG, IDX_SPARE_HI, 32'h5A5A5A5A, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, POS_MAX, POS_MIN, POS_MIN, POS_MAX,
          1'b0, 32'sd0, 32'sd0},
        '{ROW_STEP, CFG_TIME_STEP, 32'd0, 24'sd1, 24'sd1, 24'sd0, 24'sd0,
          1'b0, 32'sd0, 32'sd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tapid_in_if  step_if ();
    tapid_out_if drive_if ();
    tapid_cfg_if cfg_if ();

    two_axis_pid_controller u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step_if),
        .o_drive (drive_if),
        .i_cfg   (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of registers and loop state
    logic [StepW-1:0]         dt_reg;
    logic [GainW-1:0]         kp_reg;
    logic [GainW-1:0]         ki_reg;
    logic [GainW-1:0]         kd_reg;
    logic signed [DriveW-1:0] hi_clamp;
    logic signed [DriveW-1:0] lo_clamp;
    logic signed [IntegW-1:0] integ_sum [2];
    logic signed [ErrW-1:0]   last_err [2];

    t_drive_pair expected_drives [$];
    int          fail_count;
    bit          send_gaps_off;
    bit          take_stalls_off;

    function automatic logic signed [DriveW-1:0] axis_drive(input int ax,
            input logic signed [PosW-1:0] aim, input logic signed [PosW-1:0] pos);
        t_wide err;
        t_wide acc;
        t_wide prev;
        t_wide total;
        t_wide dt_w;
        t_wide kp_w;
        t_wide ki_w;
        t_wide kd_w;
        err  = aim - pos;
        prev = last_err[ax];
        dt_w = dt_reg;
        kp_w = kp_reg;
        ki_w = ki_reg;
        kd_w = kd_reg;
        acc  = integ_sum[ax];
        acc  = acc + err * dt_w;
        if (acc > INTEG_MAX) begin
            acc = INTEG_MAX;
        end else if (acc < INTEG_MIN) begin
            acc = INTEG_MIN;
        end
        integ_sum[ax] = acc[IntegW-1:0];
        last_err[ax]  = err[ErrW-1:0];
        total = ((err * kp_w) >>> 8) + ((acc * ki_w) >>> 24)
              + (((err - prev) * kd_w) >>> 8);
        if (total > hi_clamp) begin
            total = hi_clamp;
        end else if (total < lo_clamp) begin
            total = lo_clamp;
        end
        return total[DriveW-1:0];
    endfunction

    function automatic t_drive_pair pid_predict(input logic cmd,
            input logic signed [PosW-1:0] ax, input logic signed [PosW-1:0] ay,
            input logic signed [PosW-1:0] px, input logic signed [PosW-1:0] py);
        t_drive_pair res;
        if (cmd == CMD_CLEAR) begin
            integ_sum[0] = '0;
            integ_sum[1] = '0;
            last_err[0]  = '0;
            last_err[1]  = '0;
            res.x = '0;
            res.y = '0;
        end else begin
            res.x = axis_drive(0, ax, px);
            res.y = axis_drive(1, ay, py);
        end
        return res;
    endfunction

    function automatic logic [PosW-1:0] rand_pos();
        logic [PosW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = PosW'($urandom_range(0, 8191) - 4096);
            5, 6, 7, 8:    v = PosW'($urandom());
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = POS_MAX;
                    1:       v = POS_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    // large magnitude of a chosen sign, used to drive the integral into saturation
    function automatic logic [PosW-1:0] far_pos(input bit high);
        return {high ? 2'b01 : 2'b10, 22'($urandom())};
    endfunction

    function automatic logic [GainW-1:0] pick_gain();
        logic [GainW-1:0] g;
        case ($urandom_range(0, 4))
            0:       g = '0;
            1:       g = '1;
            2:       g = $urandom();
            default: g = $urandom_range(0, 32'h0002_0000);
        endcase
        return g;
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            CFG_TIME_STEP:  dt_reg   = data[StepW-1:0];
            CFG_PROP_GAIN:  kp_reg   = data;
            CFG_INTEG_GAIN: ki_reg   = data;
            CFG_DERIV_GAIN: kd_reg   = data;
            CFG_OUT_MAX:    hi_clamp = data;
            CFG_OUT_MIN:    lo_clamp = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle();
        step_if.valid <= 1'b0;
        cfg_if.valid  <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_step(input logic cmd,
            input logic [PosW-1:0] ax, input logic [PosW-1:0] ay,
            input logic [PosW-1:0] px, input logic [PosW-1:0] py,
            input bit typed, input t_drive_pair fixed);
        int unsigned gap;
        t_drive_pair want;
        gap = send_gaps_off ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            step_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        step_if.valid   <= 1'b1;
        step_if.command <= cmd;
        step_if.aim_x   <= ax;
        step_if.aim_y   <= ay;
        step_if.pos_x   <= px;
        step_if.pos_y   <= py;
        do @(posedge i_clk); while (!(step_if.valid && step_if.ready));
        want = pid_predict(cmd, ax, ay, px, py);
        if (typed) begin
            want = fixed;
        end
        expected_drives.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic configure_phase(input bit saturate);
        logic [CfgDatW-1:0] a;
        logic [CfgDatW-1:0] b;
        logic [CfgDatW-1:0] hi;
        logic [CfgDatW-1:0] lo;
        a = $urandom();
        b = $urandom();
        if ($signed(a) < $signed(b)) begin
            lo = a;
            hi = b;
        end else begin
            lo = b;
            hi = a;
        end
        if (saturate) begin
            write_reg(CFG_TIME_STEP, {16'($urandom()), 16'hFFFF});
            write_reg(CFG_PROP_GAIN, $urandom_range(0, 255));
            write_reg(CFG_INTEG_GAIN, $urandom_range(1, 255));
            write_reg(CFG_DERIV_GAIN, $urandom_range(0, 255));
            write_reg(CFG_OUT_MAX, RST_OUT_MAX);
            write_reg(CFG_OUT_MIN, RST_OUT_MIN);
        end else begin
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_TIME_STEP, {16'($urandom()), 16'h0000});
                1:       write_reg(CFG_TIME_STEP, {16'($urandom()), 16'hFFFF});
                default: write_reg(CFG_TIME_STEP, $urandom());
            endcase
            write_reg(CFG_PROP_GAIN, pick_gain());
            write_reg(CFG_INTEG_GAIN, pick_gain());
            write_reg(CFG_DERIV_GAIN, pick_gain());
            case ($urandom_range(0, 3))
                0: begin
                    hi = RST_OUT_MAX;
                    lo = RST_OUT_MIN;
                end
                1: begin
                    // crossed limits
                    a  = hi;
                    hi = lo;
                    lo = a;
                end
                2: begin
                    hi = $urandom_range(0, 1 << 24);
                    lo = 32'(-int'($urandom_range(0, 1 << 24)));
                end
                default: ;
            endcase
            write_reg(CFG_OUT_MAX, hi);
            write_reg(CFG_OUT_MIN, lo);
            if ($urandom_range(0, 2) == 0) begin
                write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO, $urandom());
            end
        end
    endtask

    initial begin : drive_sink
        int unsigned stall;
        drive_if.ready <= 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = take_stalls_off ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                drive_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            drive_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(drive_if.valid && drive_if.ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : drive_check
        t_drive_pair want;
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            if (expected_drives.size() == 0) begin
                $error("unexpected drive item: drive_x %0d drive_y %0d",
                       drive_if.drive_x, drive_if.drive_y);
                fail_count++;
            end else begin
                want = expected_drives.pop_front();
                if (drive_if.drive_x !== want.x) begin
                    $error("drive_x mismatch: expected %0d, got %0d", want.x, drive_if.drive_x);
                    fail_count++;
                end
                if (drive_if.drive_y !== want.y) begin
                    $error("drive_y mismatch: expected %0d, got %0d", want.y, drive_if.drive_y);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #1000000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_dir_row    row;
        t_drive_pair fixed;
        t_drive_pair none;
        logic        cmd;
        bit          saturate;
        int          phase;
        int          n;
        int          waited;
        fail_count      = 0;
        send_gaps_off   = 1'b0;
        take_stalls_off = 1'b0;
        none            = '{'0, '0};
        dt_reg          = RST_TIME_STEP;
        kp_reg          = RST_PROP_GAIN;
        ki_reg          = RST_INTEG_GAIN;
        kd_reg          = RST_DERIV_GAIN;
        hi_clamp        = RST_OUT_MAX;
        lo_clamp        = RST_OUT_MIN;
        integ_sum[0]    = '0;
        integ_sum[1]    = '0;
        last_err[0]     = '0;
        last_err[1]     = '0;

        i_rst_n         <= 1'b0;
        step_if.valid   <= 1'b0;
        step_if.command <= CMD_STEP;
        step_if.aim_x   <= '0;
        step_if.aim_y   <= '0;
        step_if.pos_x   <= '0;
        step_if.pos_y   <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_TIME_STEP;
        cfg_if.data     <= '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (n = 0; n < NUM_DIRECTED; n++) begin
            row = DIRECTED[n];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.data);
            end else begin
                cfg_if.valid <= 1'b0;
                fixed = '{row.ex, row.ey};
                send_step(row.kind == ROW_CLEAR ? CMD_CLEAR : CMD_STEP,
                          row.ax, row.ay, row.px, row.py, row.typed, fixed);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            saturate = (phase % 4 == 3);
            settle();
            send_gaps_off   = (phase % 3 == 1);
            take_stalls_off = (phase % 4 == 2);
            configure_phase(saturate);
            cfg_if.valid <= 1'b0;
            for (n = 0; n < (saturate ? SAT_ITEMS : MIX_ITEMS); n++) begin
                if (!saturate) begin
                    cmd = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_STEP;
                    send_step(cmd, rand_pos(), rand_pos(), rand_pos(), rand_pos(), 1'b0, none);
                end else if ($urandom_range(0, 19) == 0) begin
                    send_step(CMD_STEP, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                              1'b0, none);
                end else begin
                    // x pushed one way, y the other, reversed after the turn
                    send_step(CMD_STEP, far_pos(n < SAT_TURN), far_pos(n >= SAT_TURN),
                              far_pos(n >= SAT_TURN), far_pos(n < SAT_TURN), 1'b0, none);
                end
            end
        end

        step_if.valid <= 1'b0;
        waited = 0;
        while (expected_drives.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_drives.size() != 0) begin
            $error("drive items missing: %0d still pending", expected_drives.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
